// ===== src/cha_pkg.sv =====
// cha_pkg: shared types, codes and state encoding for the convex hull area engine
// no dependencies
`default_nettype none
package cha_pkg;

    localparam int unsigned CoordW = 16;
    localparam int unsigned AreaW  = 48;
    localparam int unsigned CntW   = 9;

    typedef enum logic [1:0] {
        K_CLEAR  = 2'd0,
        K_ADD    = 2'd1,
        K_REMOVE = 2'd2,
        K_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_DONE    = 2'd0,
        S_FULL    = 2'd1,
        S_NOMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [CoordW-1:0] x_coord;
        logic signed [CoordW-1:0] y_coord;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [AreaW-1:0] doubled_area;
        logic [CntW-1:0]  hull_size;
        logic [CntW-1:0]  point_count;
    } t_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RM_RD,
        ST_RM_CMP,
        ST_RM_SHIFT_RD,
        ST_RM_SHIFT_WR,
        ST_CP_RD,
        ST_CP_WR,
        ST_SO_RDV,
        ST_SO_LATV,
        ST_SO_RDJ,
        ST_SO_CMP,
        ST_SO_PLACE,
        ST_HU_RDP,
        ST_HU_LATP,
        ST_HU_RDA,
        ST_HU_LATA,
        ST_HU_RDB,
        ST_HU_LATB,
        ST_HU_MUL,
        ST_HU_DEC,
        ST_AR_RD1,
        ST_AR_LAT1,
        ST_AR_RD2,
        ST_AR_LAT2,
        ST_AR_MUL,
        ST_AR_ACC,
        ST_DONE
    } t_state;

    // operands for the shared cross-product unit (a*b - c*d)
    typedef struct packed {
        logic signed [CoordW:0] a;
        logic signed [CoordW:0] b;
        logic signed [CoordW:0] c;
        logic signed [CoordW:0] d;
    } t_mul_op;

endpackage
`default_nettype wire

// ===== src/cha_cross_unit.sv =====
// cha_cross_unit: shared registered unit computing a*b - c*d on 17-bit signed operands
// depends on cha_pkg
`default_nettype none
module cha_cross_unit (
    input  wire logic             i_clk,
    input  wire cha_pkg::t_mul_op i_op,
    output logic signed [35:0]    o_res
);
    logic signed [33:0] r_p1;
    logic signed [33:0] r_p2;

    // two products registered, difference registered next cycle
    always_ff @(posedge i_clk) begin
        r_p1  <= i_op.a * i_op.b;
        r_p2  <= i_op.c * i_op.d;
        o_res <= 36'(r_p1) - 36'(r_p2);
    end
endmodule
`default_nettype wire

// ===== src/convex_hull_area_engine.sv =====
// convex_hull_area_engine: top level with point store, sort and hull sequencer
// depends on cha_pkg and cha_cross_unit
`default_nettype none
// usage
//   request channel: drive i_req with i_start high; it is taken on a rising edge while
//   o_busy is low. exactly one result follows, shown on o_rsp for one cycle with o_done.
//   the receiver cannot stall; a result must be sampled in the cycle o_done is high.
// sequence
//   clear and add: the sequencer goes to ST_DONE, which registers the result and raises
//   o_done; o_busy stays high until o_done falls.
//   remove: stored points are read and compared until the first match, then each later
//   point is read and written one place down.
//   query: copy into the sort buffer, insertion sort (order n^2 compares worst), hull
//   by cross-product tests and pushes, then one area term per hull vertex.
//   the run time is set by the point memories (one read and one write port each) and
//   the one shared cross-product unit (a*b - c*d, two registered stages) used by every
//   test and area term.
// reset
//   synchronous active-low i_rst_n empties the set and returns the sequencer to idle.
//   memory contents are not cleared; only entries below the count are ever read.
// throughput
//   one request at a time; the next is taken the cycle after o_done.
module convex_hull_area_engine #(
    parameter int unsigned MAX_POINTS = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire cha_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_done,
    output cha_pkg::t_rsp      o_rsp
);
    localparam int unsigned AW  = $clog2(MAX_POINTS);
    localparam int unsigned HAW = AW + 1;
    localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
    localparam int unsigned KW  = HAW + 1;

    typedef logic signed [cha_pkg::CoordW-1:0] t_c;

    // memories: point store, sort buffer, hull stack
    logic [2*cha_pkg::CoordW-1:0] r_pts  [MAX_POINTS];
    logic [2*cha_pkg::CoordW-1:0] r_srt  [MAX_POINTS];
    logic [2*cha_pkg::CoordW-1:0] r_hul  [2*MAX_POINTS];

    cha_pkg::t_state r_st, n_st;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_i, n_i;      // main index
    logic [KW-1:0]  r_j, n_j;      // inner sort index
    logic [KW-1:0]  r_k, n_k;
    logic [KW-1:0]  r_t, n_t;
    logic           r_up, n_up;    // hull phase: 0 lower, 1 upper
    logic [1:0]     r_stat, n_stat;
    logic signed [49:0] r_sum, n_sum;
    logic [31:0]    r_v, n_v;      // held sort value / hull point
    logic [31:0]    r_a, n_a;
    logic [31:0]    r_b, n_b;
    logic           r_done, n_done;
    logic [1:0]     r_mw, n_mw;    // wait counter for cross unit
    cha_pkg::t_rsp  r_rsp, n_rsp;

    // memory ports
    logic           pts_we, srt_we, hul_we;
    logic [AW-1:0]  pts_wa, pts_ra, srt_wa, srt_ra;
    logic [HAW-1:0] hul_wa, hul_ra;
    logic [31:0]    pts_wd, srt_wd, hul_wd;
    logic [31:0]    r_pts_q, r_srt_q, r_hul_q;

    always_ff @(posedge i_clk) begin
        if (pts_we) begin
            r_pts[pts_wa] <= pts_wd;
        end
        if (srt_we) begin
            r_srt[srt_wa] <= srt_wd;
        end
        if (hul_we) begin
            r_hul[hul_wa] <= hul_wd;
        end
        r_pts_q <= r_pts[pts_ra];
        r_srt_q <= r_srt[srt_ra];
        r_hul_q <= r_hul[hul_ra];
    end

    // shared cross-product unit
    cha_pkg::t_mul_op mop;
    logic signed [35:0] mres;

    cha_cross_unit u_cross (
        .i_clk (i_clk),
        .i_op  (mop),
        .o_res (mres)
    );

    function automatic logic pt_less(input logic [31:0] a, input logic [31:0] b);
        t_c ax, ay, bx, by;
        ax = a[31:16];
        ay = a[15:0];
        bx = b[31:16];
        by = b[15:0];
        return (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

    function automatic logic signed [16:0] sx(input logic [15:0] v);
        return {v[15], v};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= cha_pkg::ST_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_t    <= n_t;
        r_up   <= n_up;
        r_stat <= n_stat;
        r_sum  <= n_sum;
        r_v    <= n_v;
        r_a    <= n_a;
        r_b    <= n_b;
        r_mw   <= n_mw;
        r_rsp  <= n_rsp;
    end

    logic [31:0] req_pt;
    assign req_pt = {i_req.x_coord, i_req.y_coord};

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_i    = r_i;
        n_j    = r_j;
        n_k    = r_k;
        n_t    = r_t;
        n_up   = r_up;
        n_stat = r_stat;
        n_sum  = r_sum;
        n_v    = r_v;
        n_a    = r_a;
        n_b    = r_b;
        n_mw   = r_mw;
        n_rsp  = r_rsp;
        n_done = 1'b0;
        pts_we = 1'b0;
        srt_we = 1'b0;
        hul_we = 1'b0;
        pts_wa = r_i[AW-1:0];
        pts_ra = r_i[AW-1:0];
        srt_wa = r_i[AW-1:0];
        srt_ra = r_i[AW-1:0];
        hul_wa = r_k[HAW-1:0];
        hul_ra = r_k[HAW-1:0];
        pts_wd = req_pt;
        srt_wd = r_pts_q;
        hul_wd = r_v;
        mop.a  = sx(r_a[31:16]);
        mop.b  = sx(r_b[15:0]);
        mop.c  = sx(r_a[15:0]);
        mop.d  = sx(r_b[31:16]);

        case (r_st)
            cha_pkg::ST_IDLE: begin
                // the result cycle still shows busy, so no request is taken then
                if (i_start && !r_done) begin
                    n_stat = cha_pkg::S_DONE;
                    n_i    = '0;
                    n_k    = '0;
                    case (cha_pkg::t_kind'(i_req.kind))
                        cha_pkg::K_CLEAR: begin
                            n_cnt = '0;
                            n_st  = cha_pkg::ST_DONE;
                        end
                        cha_pkg::K_ADD: begin
                            if (r_cnt >= CW'(MAX_POINTS)) begin
                                n_stat = cha_pkg::S_FULL;
                            end else begin
                                pts_we = 1'b1;
                                pts_wa = r_cnt[AW-1:0];
                                n_cnt  = r_cnt + 1'b1;
                            end
                            n_st = cha_pkg::ST_DONE;
                        end
                        cha_pkg::K_REMOVE: begin
                            n_v    = req_pt;
                            n_stat = cha_pkg::S_NOMATCH;
                            n_st   = cha_pkg::ST_RM_RD;
                        end
                        default: begin
                            if (r_cnt == '0) begin
                                n_st = cha_pkg::ST_DONE;
                            end else begin
                                n_st = cha_pkg::ST_CP_RD;
                            end
                        end
                    endcase
                end
            end

            // remove: scan for the first match, then shift the tail down
            cha_pkg::ST_RM_RD: begin
                if (r_i >= r_cnt) begin
                    n_st = cha_pkg::ST_DONE;
                end else begin
                    n_st = cha_pkg::ST_RM_CMP;
                end
            end
            cha_pkg::ST_RM_CMP: begin
                if (r_pts_q == r_v) begin
                    n_stat = cha_pkg::S_DONE;
                    n_st   = cha_pkg::ST_RM_SHIFT_RD;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_st = cha_pkg::ST_RM_RD;
                end
            end
            cha_pkg::ST_RM_SHIFT_RD: begin
                if (r_i + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_st  = cha_pkg::ST_DONE;
                end else begin
                    pts_ra = AW'(r_i + 1'b1);
                    n_st   = cha_pkg::ST_RM_SHIFT_WR;
                end
            end
            cha_pkg::ST_RM_SHIFT_WR: begin
                pts_we = 1'b1;
                pts_wd = r_pts_q;
                n_i    = r_i + 1'b1;
                n_st   = cha_pkg::ST_RM_SHIFT_RD;
            end

            // query: copy store into sort buffer
            cha_pkg::ST_CP_RD: begin
                n_st = cha_pkg::ST_CP_WR;
            end
            cha_pkg::ST_CP_WR: begin
                srt_we = 1'b1;
                if (r_i + 1'b1 >= r_cnt) begin
                    if (r_cnt == CW'(1)) begin
                        n_v  = r_pts_q;
                        n_k  = '0;
                        hul_we = 1'b1;
                        hul_wd = r_pts_q;
                        n_k  = KW'(1);
                        n_st = cha_pkg::ST_DONE;
                    end else begin
                        n_i  = CW'(1);
                        n_st = cha_pkg::ST_SO_RDV;
                    end
                end else begin
                    n_i  = r_i + 1'b1;
                    n_st = cha_pkg::ST_CP_RD;
                end
            end

            // insertion sort
            cha_pkg::ST_SO_RDV: begin
                if (r_i >= r_cnt) begin
                    n_i  = '0;
                    n_k  = '0;
                    n_up = 1'b0;
                    n_st = cha_pkg::ST_HU_RDP;
                end else begin
                    n_st = cha_pkg::ST_SO_LATV;
                end
            end
            cha_pkg::ST_SO_LATV: begin
                n_v  = r_srt_q;
                n_j  = KW'(r_i);   // insertion position; compare against j-1
                n_st = cha_pkg::ST_SO_RDJ;
            end
            cha_pkg::ST_SO_RDJ: begin
                if (r_j == '0) begin
                    n_st = cha_pkg::ST_SO_PLACE;
                end else begin
                    srt_ra = AW'(r_j - 1'b1);
                    n_st   = cha_pkg::ST_SO_CMP;
                end
            end
            cha_pkg::ST_SO_CMP: begin
                if (pt_less(r_v, r_srt_q)) begin
                    srt_we = 1'b1;
                    srt_wa = r_j[AW-1:0];
                    srt_wd = r_srt_q;
                    n_j    = r_j - 1'b1;
                    n_st   = cha_pkg::ST_SO_RDJ;
                end else begin
                    n_st = cha_pkg::ST_SO_PLACE;
                end
            end
            cha_pkg::ST_SO_PLACE: begin
                srt_we = 1'b1;
                srt_wa = r_j[AW-1:0];
                srt_wd = r_v;
                n_i    = r_i + 1'b1;
                n_st   = cha_pkg::ST_SO_RDV;
            end

            // monotone chain: r_i walks sorted points (up, then down)
            cha_pkg::ST_HU_RDP: begin
                n_st = cha_pkg::ST_HU_LATP;
            end
            cha_pkg::ST_HU_LATP: begin
                n_v  = r_srt_q;
                n_st = cha_pkg::ST_HU_RDA;
            end
            cha_pkg::ST_HU_RDA: begin
                if ((!r_up && r_k >= KW'(2)) || (r_up && r_k >= r_t)) begin
                    hul_ra = HAW'(r_k - KW'(2));
                    n_st   = cha_pkg::ST_HU_LATA;
                end else begin
                    n_st = cha_pkg::ST_HU_DEC;
                end
            end
            cha_pkg::ST_HU_LATA: begin
                n_a    = r_hul_q;
                hul_ra = HAW'(r_k - 1'b1);
                n_st   = cha_pkg::ST_HU_RDB;
            end
            cha_pkg::ST_HU_RDB: begin
                // keep the top-of-stack address until its data is latched
                hul_ra = HAW'(r_k - 1'b1);
                n_st   = cha_pkg::ST_HU_LATB;
            end
            cha_pkg::ST_HU_LATB: begin
                // latch A; the 17-bit differences A - O and P - O are formed in ST_HU_MUL
                n_b  = r_hul_q;
                n_mw = '0;
                n_st = cha_pkg::ST_HU_MUL;
            end
            cha_pkg::ST_HU_MUL: begin
                // cross = (A-O)x*(P-O)y - (A-O)y*(P-O)x, O=r_a A=r_b P=r_v
                mop.a = sx(r_b[31:16]) - sx(r_a[31:16]);
                mop.b = sx(r_v[15:0])  - sx(r_a[15:0]);
                mop.c = sx(r_b[15:0])  - sx(r_a[15:0]);
                mop.d = sx(r_v[31:16]) - sx(r_a[31:16]);
                n_mw  = r_mw + 1'b1;
                if (r_mw == 2'd2) begin
                    if (mres <= 0) begin
                        n_k  = r_k - 1'b1;
                        n_st = cha_pkg::ST_HU_RDA;
                    end else begin
                        n_st = cha_pkg::ST_HU_DEC;
                    end
                end
            end
            cha_pkg::ST_HU_DEC: begin
                // push and advance
                hul_we = 1'b1;
                n_k    = r_k + 1'b1;
                if (!r_up) begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        n_up = 1'b1;
                        n_t  = r_k + KW'(2);
                        n_i  = r_cnt - CW'(2);
                        n_st = cha_pkg::ST_HU_RDP;
                    end else begin
                        n_i  = r_i + 1'b1;
                        n_st = cha_pkg::ST_HU_RDP;
                    end
                end else begin
                    if (r_i == '0) begin
                        // hull size is k-1 after this push, i.e. r_k
                        n_sum = '0;
                        n_i   = '0;
                        if (r_k >= KW'(3)) begin
                            n_st = cha_pkg::ST_AR_RD1;
                        end else begin
                            n_st = cha_pkg::ST_DONE;
                        end
                    end else begin
                        n_i  = r_i - 1'b1;
                        n_st = cha_pkg::ST_HU_RDP;
                    end
                end
            end

            // shoelace over m = r_k - 1 vertices; vertex m equals vertex 0
            cha_pkg::ST_AR_RD1: begin
                hul_ra = HAW'(r_i);
                n_st   = cha_pkg::ST_AR_LAT1;
            end
            cha_pkg::ST_AR_LAT1: begin
                n_a    = r_hul_q;
                hul_ra = HAW'(r_i + 1'b1);
                n_st   = cha_pkg::ST_AR_RD2;
            end
            cha_pkg::ST_AR_RD2: begin
                hul_ra = HAW'(r_i + 1'b1);
                n_st   = cha_pkg::ST_AR_LAT2;
            end
            cha_pkg::ST_AR_LAT2: begin
                n_b  = r_hul_q;
                n_mw = '0;
                n_st = cha_pkg::ST_AR_MUL;
            end
            cha_pkg::ST_AR_MUL: begin
                n_mw = r_mw + 1'b1;
                if (r_mw == 2'd2) begin
                    n_st = cha_pkg::ST_AR_ACC;
                end
            end
            cha_pkg::ST_AR_ACC: begin
                n_sum = r_sum + 50'(mres);
                if (KW'(r_i) + KW'(2) >= r_k) begin
                    n_st = cha_pkg::ST_DONE;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_st = cha_pkg::ST_AR_RD1;
                end
            end

            cha_pkg::ST_DONE: begin
                n_rsp.status       = r_stat;
                n_rsp.point_count  = cha_pkg::CntW'(r_cnt);
                n_rsp.doubled_area = '0;
                n_rsp.hull_size    = '0;
                if (r_k != '0) begin
                    // query ran: single point leaves k=1, else k-1 vertices
                    if (r_cnt == CW'(1)) begin
                        n_rsp.hull_size = cha_pkg::CntW'(1);
                    end else begin
                        n_rsp.hull_size = cha_pkg::CntW'(r_k - 1'b1);
                        if (r_k >= KW'(4)) begin
                            n_rsp.doubled_area = r_sum[49] ? 48'(-r_sum) : 48'(r_sum);
                        end
                    end
                end
                n_done = 1'b1;
                n_st   = cha_pkg::ST_IDLE;
            end

            default: begin
                n_st = cha_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_st != cha_pkg::ST_IDLE) || r_done;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule
`default_nettype wire

// ===== src/cha_checker.sv =====
// cha_checker: port-level assertions for the convex hull area engine
// depends on cha_pkg and convex_hull_area_engine
`default_nettype none
module cha_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire cha_pkg::t_req i_req,
    input wire logic          o_busy,
    input wire logic          o_done,
    input wire cha_pkg::t_rsp o_rsp
);
    // a taken request makes the block busy next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("not busy after request");

    // results come one cycle at a time
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held");

    // status code never out of range
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status != 2'd3))
        else $error("bad status");

    // results with fewer than three hull vertices carry no area
    a_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.hull_size < 9'd3) |-> (o_rsp.doubled_area == '0))
        else $error("area without hull");
endmodule

bind convex_hull_area_engine cha_checker u_cha_checker (.*);
`default_nettype wire
